>>> rtl/core/qmn_pkg.sv
// qmn_pkg: types and constants shared by the quaternion multiply-normalize block.
// Used by every module in rtl/core; no dependencies of its own.
package qmn_pkg;

  localparam int unsigned ProdW    = 34;  // hamilton product component, Q6.28 signed
  localparam int unsigned SumSqW   = 33;  // sum of four squares, Q5.28 unsigned
  localparam int unsigned MagW     = 37;  // squared magnitude of the product, Q9.28
  localparam int unsigned RootW    = 29;  // sqrt(mag) with 24 fraction bits
  localparam int unsigned RemW     = 30;  // sqrt partial remainder
  localparam int unsigned DivisorW = 30;
  localparam int unsigned NumW     = 48;  // rounded numerator magnitude
  localparam int unsigned QuotW    = 17;  // quotient bits kept before saturation
  localparam int unsigned FrontStages = 5;
  localparam int unsigned FifoDepth   = 4;
  localparam int unsigned FifoPtrW    = 2;

  localparam logic [MagW-1:0] MagOne   = MagW'(64'h1000_0000);
  localparam logic [MagW-1:0] MagNearLo = MagW'(64'h1000_0000 - 64'd6);
  localparam logic [MagW-1:0] MagNearHi = MagW'(64'h1000_0000 + 64'd6);
  localparam logic signed [15:0] OneQ14  = 16'sd16384;
  localparam logic signed [15:0] SatPos  = 16'sh7fff;
  localparam logic signed [15:0] SatNeg  = 16'sh8000;

  typedef struct packed {
    logic signed [15:0] a_w;
    logic signed [15:0] a_x;
    logic signed [15:0] a_y;
    logic signed [15:0] a_z;
    logic signed [15:0] b_w;
    logic signed [15:0] b_x;
    logic signed [15:0] b_y;
    logic signed [15:0] b_z;
  } qmn_in_t;

  typedef struct packed {
    logic signed [15:0] out_w;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic               zero_magnitude;
  } qmn_out_t;

  // classified product handed from front to back
  typedef struct packed {
    logic signed [ProdW-1:0] p_w;
    logic signed [ProdW-1:0] p_x;
    logic signed [ProdW-1:0] p_y;
    logic signed [ProdW-1:0] p_z;
    logic [MagW-1:0]         mag;
    logic                    near_one;
    logic                    zero;
  } qmn_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qmn_fifo_sts_t;

endpackage

>>> rtl/core/qmn_front.sv
// qmn_front: hamilton product, squared magnitude and path classification, 5 stages.
// Depends on qmn_pkg; feeds qmn_fifo.
module qmn_front import qmn_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  qmn_in_t   in_data_i,
  input  logic      full_i,
  output logic      push_o,
  output qmn_item_t item_o
);

  logic [FrontStages-1:0] v_q;
  logic en;

  logic signed [31:0] pr_q [16];
  logic signed [31:0] sa_q [4];
  logic signed [31:0] sb_q [4];
  logic signed [ProdW-1:0] p2_q [4];
  logic signed [ProdW-1:0] p3_q [4];
  logic signed [ProdW-1:0] p4_q [4];
  logic [SumSqW-1:0] asum_q, bsum_q;
  logic signed [ProdW:0] asum_w, bsum_w;
  logic [49:0] hi_q;
  logic [48:0] lo_q;
  logic [65:0] prod_sum;
  logic [MagW-1:0] mag_q;
  qmn_item_t item_q;

  assign en         = !(v_q[FrontStages-1] && full_i);
  assign in_stall_o = !en;
  assign push_o     = v_q[FrontStages-1] && !full_i;
  assign item_o     = item_q;

  assign asum_w = sa_q[0] + sa_q[1] + sa_q[2] + sa_q[3];
  assign bsum_w = sb_q[0] + sb_q[1] + sb_q[2] + sb_q[3];
  assign prod_sum = {hi_q, 16'b0} + 66'(lo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[FrontStages-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pr_q[0]  <= in_data_i.a_w * in_data_i.b_w;
      pr_q[1]  <= in_data_i.a_x * in_data_i.b_x;
      pr_q[2]  <= in_data_i.a_y * in_data_i.b_y;
      pr_q[3]  <= in_data_i.a_z * in_data_i.b_z;
      pr_q[4]  <= in_data_i.a_w * in_data_i.b_x;
      pr_q[5]  <= in_data_i.a_x * in_data_i.b_w;
      pr_q[6]  <= in_data_i.a_y * in_data_i.b_z;
      pr_q[7]  <= in_data_i.a_z * in_data_i.b_y;
      pr_q[8]  <= in_data_i.a_w * in_data_i.b_y;
      pr_q[9]  <= in_data_i.a_x * in_data_i.b_z;
      pr_q[10] <= in_data_i.a_y * in_data_i.b_w;
      pr_q[11] <= in_data_i.a_z * in_data_i.b_x;
      pr_q[12] <= in_data_i.a_w * in_data_i.b_z;
      pr_q[13] <= in_data_i.a_x * in_data_i.b_y;
      pr_q[14] <= in_data_i.a_y * in_data_i.b_x;
      pr_q[15] <= in_data_i.a_z * in_data_i.b_w;
      sa_q[0]  <= in_data_i.a_w * in_data_i.a_w;
      sa_q[1]  <= in_data_i.a_x * in_data_i.a_x;
      sa_q[2]  <= in_data_i.a_y * in_data_i.a_y;
      sa_q[3]  <= in_data_i.a_z * in_data_i.a_z;
      sb_q[0]  <= in_data_i.b_w * in_data_i.b_w;
      sb_q[1]  <= in_data_i.b_x * in_data_i.b_x;
      sb_q[2]  <= in_data_i.b_y * in_data_i.b_y;
      sb_q[3]  <= in_data_i.b_z * in_data_i.b_z;

      p2_q[0] <= ProdW'(pr_q[0]) - ProdW'(pr_q[1]) - ProdW'(pr_q[2]) - ProdW'(pr_q[3]);
      p2_q[1] <= ProdW'(pr_q[4]) + ProdW'(pr_q[5]) + ProdW'(pr_q[6]) - ProdW'(pr_q[7]);
      p2_q[2] <= ProdW'(pr_q[8]) - ProdW'(pr_q[9]) + ProdW'(pr_q[10]) + ProdW'(pr_q[11]);
      p2_q[3] <= ProdW'(pr_q[12]) + ProdW'(pr_q[13]) - ProdW'(pr_q[14]) + ProdW'(pr_q[15]);
      asum_q  <= asum_w[SumSqW-1:0];
      bsum_q  <= bsum_w[SumSqW-1:0];

      // a*b split over two partial products, summed next stage
      hi_q <= 50'(asum_q) * 50'(bsum_q[32:16]);
      lo_q <= 49'(asum_q) * 49'(bsum_q[15:0]);
      p3_q <= p2_q;

      mag_q <= prod_sum[64:28];
      p4_q  <= p3_q;

      item_q.p_w      <= p4_q[0];
      item_q.p_x      <= p4_q[1];
      item_q.p_y      <= p4_q[2];
      item_q.p_z      <= p4_q[3];
      item_q.mag      <= mag_q;
      item_q.near_one <= (mag_q > MagNearLo) && (mag_q < MagNearHi);
      item_q.zero     <= (mag_q == '0);
    end
  end

endmodule

>>> rtl/core/qmn_fifo.sv
// qmn_fifo: short queue of classified products between front and back.
// Depends on qmn_pkg.
module qmn_fifo import qmn_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  qmn_item_t     item_i,
  input  logic          pop_i,
  output qmn_item_t     item_o,
  output qmn_fifo_sts_t sts_o
);

  qmn_item_t mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_q, rd_q;
  logic [FifoPtrW:0]   cnt_q;
  logic do_pop;

  assign sts_o.full  = (cnt_q == (FifoPtrW+1)'(FifoDepth));
  assign sts_o.empty = (cnt_q == '0);
  assign item_o      = mem_q[rd_q];
  assign do_pop      = pop_i && !sts_o.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (FifoPtrW+1)'(push_i) - (FifoPtrW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

endmodule

>>> rtl/core/qmn_isqrt.sv
// qmn_isqrt: pipelined integer square root of mag * 2^20, one result bit per stage.
// Depends on qmn_pkg; carries the queued item alongside.
module qmn_isqrt import qmn_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  qmn_item_t        item_i,
  output logic             valid_o,
  output qmn_item_t        item_o,
  output logic [RootW-1:0] root_o
);

  logic             v_q    [RootW];
  qmn_item_t        item_q [RootW];
  logic [RootW-1:0] root_q [RootW];
  logic [RemW-1:0]  rem_q  [RootW];

  for (genvar k = 0; k < RootW; k++) begin : g_step
    localparam int unsigned Pair = RootW - 1 - k;
    logic             v_in;
    qmn_item_t        it_in;
    logic [RootW-1:0] root_in;
    logic [RemW-1:0]  rem_in;
    logic [57:0]      rad;
    logic [RemW+1:0]  cur;
    logic [RemW:0]    trial;
    logic             take;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign it_in   = item_i;
      assign root_in = '0;
      assign rem_in  = '0;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign it_in   = item_q[k-1];
      assign root_in = root_q[k-1];
      assign rem_in  = rem_q[k-1];
    end

    assign rad   = {1'b0, it_in.mag, 20'b0};
    assign cur   = {rem_in, rad[2*Pair+1 -: 2]};
    assign trial = {root_in, 2'b01};
    assign take  = (cur >= (RemW+2)'(trial));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        item_q[k] <= it_in;
        root_q[k] <= {root_in[RootW-2:0], take};
        rem_q[k]  <= take ? RemW'(cur - (RemW+2)'(trial)) : cur[RemW-1:0];
      end
    end
  end

  assign valid_o = v_q[RootW-1];
  assign item_o  = item_q[RootW-1];
  assign root_o  = root_q[RootW-1];

endmodule

>>> rtl/core/qmn_div.sv
// qmn_div: four-lane pipelined rounding divide, saturation, zero-magnitude override and output register.
// Depends on qmn_pkg; takes the item and root from qmn_isqrt.
module qmn_div import qmn_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  qmn_item_t        item_i,
  input  logic [RootW-1:0] root_i,
  output logic             valid_o,
  output qmn_out_t         data_o
);

  localparam int unsigned Stages = QuotW + 1;

  logic                v_q    [Stages];
  logic                zero_q [Stages];
  logic [DivisorW-1:0] d_q    [Stages];
  logic [NumW-1:0]     r_q    [Stages][4];
  logic [QuotW-1:0]    q_q    [Stages][4];
  logic                neg_q  [Stages][4];
  logic                ov_q   [Stages][4];

  logic signed [ProdW-1:0] p_in [4];
  logic [DivisorW-1:0] d_in;

  logic     out_v_q;
  qmn_out_t out_q;
  logic signed [15:0] res [4];

  assign p_in[0] = item_i.p_w;
  assign p_in[1] = item_i.p_x;
  assign p_in[2] = item_i.p_y;
  assign p_in[3] = item_i.p_z;
  assign d_in = item_i.near_one ? DivisorW'(MagOne + item_i.mag) : DivisorW'(root_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < Stages; s++) v_q[s] <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int s = 1; s < Stages; s++) v_q[s] <= v_q[s-1];
      out_v_q <= v_q[Stages-1];
    end
  end

  // prepare: magnitude of numerator plus half divisor, overflow check
  for (genvar l = 0; l < 4; l++) begin : g_prep
    logic [SumSqW-1:0] ap;
    logic [NumW-1:0]   n;
    logic [NumW-1:0]   np;
    assign ap = p_in[l][ProdW-1] ? SumSqW'(-p_in[l]) : SumSqW'(p_in[l]);
    assign n  = item_i.near_one ? {ap, 15'b0} : {5'b0, ap, 10'b0};
    assign np = n + NumW'(d_in >> 1);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[0][l]   <= np;
        q_q[0][l]   <= '0;
        neg_q[0][l] <= p_in[l][ProdW-1];
        ov_q[0][l]  <= (np >= NumW'({d_in, 17'b0}));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q[0]    <= d_in;
      zero_q[0] <= item_i.zero;
    end
  end

  for (genvar j = 1; j < Stages; j++) begin : g_step
    localparam int unsigned Bit = QuotW - j;
    logic [NumW-1:0] dk;
    assign dk = NumW'(d_q[j-1]) << Bit;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_q[j]    <= d_q[j-1];
        zero_q[j] <= zero_q[j-1];
        for (int l = 0; l < 4; l++) begin
          neg_q[j][l] <= neg_q[j-1][l];
          ov_q[j][l]  <= ov_q[j-1][l];
          if (r_q[j-1][l] >= dk) begin
            r_q[j][l] <= r_q[j-1][l] - dk;
            q_q[j][l] <= q_q[j-1][l] | (QuotW'(1) << Bit);
          end else begin
            r_q[j][l] <= r_q[j-1][l];
            q_q[j][l] <= q_q[j-1][l];
          end
        end
      end
    end
  end

  // round was folded into the numerator; saturate and apply sign
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      if (neg_q[Stages-1][l]) begin
        if (ov_q[Stages-1][l] || q_q[Stages-1][l] > QuotW'(32768)) res[l] = SatNeg;
        else res[l] = 16'(-q_q[Stages-1][l]);
      end else begin
        if (ov_q[Stages-1][l] || q_q[Stages-1][l] > QuotW'(32767)) res[l] = SatPos;
        else res[l] = 16'(q_q[Stages-1][l]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (zero_q[Stages-1]) begin
        out_q.out_w <= OneQ14;
        out_q.out_x <= '0;
        out_q.out_y <= '0;
        out_q.out_z <= '0;
      end else begin
        out_q.out_w <= res[0];
        out_q.out_x <= res[1];
        out_q.out_y <= res[2];
        out_q.out_z <= res[3];
      end
      out_q.zero_magnitude <= zero_q[Stages-1];
    end
  end

  assign valid_o = out_v_q;
  assign data_o  = out_q;

endmodule

>>> rtl/core/quaternion_multiply_normalize.sv
// quaternion_multiply_normalize: normalized hamilton product a*b in Q2.14.
// Depends on qmn_pkg, qmn_front, qmn_fifo, qmn_isqrt and qmn_div.
//
// Input channel: in_valid_i / in_stall_o / in_data_i carry one operand pair a, b
// per beat. Output channel: out_valid_o / out_stall_i / out_data_o carry the
// normalized product and the zero_magnitude flag, one beat per input beat, in order.
// Throughput is one beat per cycle while out_stall_i is low. An input beat passes
// through 5 front stages (products, four-square sums, split magnitude multiply,
// partial-product sum, classify), the queue's storage register, 29 square root
// stages (one root bit each), one divide setup stage, 17 quotient stages and the
// output register before output valid.
// The front and back halves are parted by a 4-entry queue. When the receiver
// stalls, the back half freezes with its result held in the output register;
// the front keeps accepting until the queue is full and a beat waits in its
// last stage, then raises in_stall_o. Reset clears all valid bits and the queue;
// no beat is lost or repeated across a stall.
module quaternion_multiply_normalize import qmn_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  qmn_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output qmn_out_t out_data_o
);

  qmn_item_t     f_item, q_item, s_item;
  qmn_fifo_sts_t q_sts;
  logic          push, back_en, s_valid;
  logic [RootW-1:0] s_root;

  assign back_en = !(out_valid_o && out_stall_i);

  qmn_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .full_i     (q_sts.full),
    .push_o     (push),
    .item_o     (f_item)
  );

  qmn_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (f_item),
    .pop_i  (back_en),
    .item_o (q_item),
    .sts_o  (q_sts)
  );

  qmn_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (back_en),
    .valid_i (!q_sts.empty),
    .item_i  (q_item),
    .valid_o (s_valid),
    .item_o  (s_item),
    .root_o  (s_root)
  );

  qmn_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (back_en),
    .valid_i (s_valid),
    .item_i  (s_item),
    .root_i  (s_root),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

endmodule

>>> verif/tb_quaternion_multiply_normalize.sv
// tb_quaternion_multiply_normalize: randomized self-checking bench for the
// normalized quaternion product; depends on qmn_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_quaternion_multiply_normalize;
  import qmn_pkg::*;

  class qprod_board;
    qmn_out_t want_q[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    static function longint rnd_div(longint n, longint d);
      if (n >= 0) return (n + d / 2) / d;
      return -((-n + d / 2) / d);
    endfunction

    static function logic signed [15:0] clip16(longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
    endfunction

    static function longint unsigned root64(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    static function qmn_out_t norm_product(qmn_in_t q);
      longint aw, ax, ay, az, bw, bx, by, bz, mg, df, s;
      longint p[4];
      longint unsigned sa, sb, mu;
      qmn_out_t r;
      logic signed [15:0] o[4];
      aw = q.a_w; ax = q.a_x; ay = q.a_y; az = q.a_z;
      bw = q.b_w; bx = q.b_x; by = q.b_y; bz = q.b_z;
      p[0] = aw*bw - ax*bx - ay*by - az*bz;
      p[1] = aw*bx + ax*bw + ay*bz - az*by;
      p[2] = aw*by - ax*bz + ay*bw + az*bx;
      p[3] = aw*bz + ax*by - ay*bx + az*bw;
      sa = aw*aw + ax*ax + ay*ay + az*az;
      sb = bw*bw + bx*bx + by*by + bz*bz;
      mu = sa * (sb >> 28) + ((sa * (sb & 64'h0FFF_FFFF)) >> 28);
      mg = mu;
      if (mg == 0) begin
        r.out_w = OneQ14; r.out_x = 0; r.out_y = 0; r.out_z = 0;
        r.zero_magnitude = 1'b1;
        return r;
      end
      df = mg - (64'd1 << 28);
      if (df < 0) df = -df;
      if (df < 6) begin
        for (int i = 0; i < 4; i++)
          o[i] = clip16(rnd_div(p[i] * 32768, (64'd1 << 28) + mg));
      end else begin
        s = root64(mu << 20);
        for (int i = 0; i < 4; i++) o[i] = clip16(rnd_div(p[i] * 1024, s));
      end
      r.out_w = o[0]; r.out_x = o[1]; r.out_y = o[2]; r.out_z = o[3];
      r.zero_magnitude = 1'b0;
      return r;
    endfunction

    function void note_operands(qmn_in_t q);
      want_q.push_back(norm_product(q));
    endfunction

    function void check_result(qmn_out_t got);
      qmn_out_t w;
      if (want_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      w = want_q.pop_front();
      if (got.out_w !== w.out_w || got.out_x !== w.out_x || got.out_y !== w.out_y ||
          got.out_z !== w.out_z || got.zero_magnitude !== w.zero_magnitude) begin
        $display("%0t: mismatch, expected w=%0d x=%0d y=%0d z=%0d zm=%0b",
                 $time, w.out_w, w.out_x, w.out_y, w.out_z, w.zero_magnitude);
        $display("%0t:           actual   w=%0d x=%0d y=%0d z=%0d zm=%0b",
                 $time, got.out_w, got.out_x, got.out_y, got.out_z, got.zero_magnitude);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  qmn_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  qmn_out_t out_data_o;

  qprod_board board = new();
  bit calm = 1'b0;
  qmn_in_t op_q[$];

  quaternion_multiply_normalize uut (.*);

  always #2 clk_i = ~clk_i;

  // checks and accepted beats at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) board.note_operands(in_data_i);
    if (rst_ni && out_valid_o && !out_stall_i) board.check_result(out_data_o);
  end

  // receiver stall bursts
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 18);
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk_i);
    end
  end

  function automatic logic [15:0] pick_comp();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'h4000;
      4: return 16'hc000;
      5: return 16'(int'($urandom_range(0, 8)) - 4);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic qmn_in_t mk_quat(logic [15:0] w, x, y, z, logic [15:0] bw2, bx2,
                                      by2, bz2);
    qmn_in_t q;
    q.a_w = w; q.a_x = x; q.a_y = y; q.a_z = z;
    q.b_w = bw2; q.b_x = bx2; q.b_y = by2; q.b_z = bz2;
    return q;
  endfunction

  // one beat; valid stays high between back-to-back beats
  task automatic send_operands(qmn_in_t q);
    in_data_i <= q;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 6) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
  endtask

  task automatic drain_all();
    in_valid_i <= 1'b0;
    while (board.want_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    qmn_in_t q;
    logic [15:0] c[8];
    op_q.push_back(mk_quat(16'h4000, 0, 0, 0, 16'h4000, 0, 0, 0));
    op_q.push_back(mk_quat(0, 16'h4000, 0, 0, 0, 0, 16'h4000, 0));
    op_q.push_back(mk_quat(0, 0, 0, 0, 16'h1234, 16'h0001, 0, 0));
    op_q.push_back(mk_quat(16'h0001, 0, 0, 0, 16'h0001, 0, 0, 0));
    op_q.push_back(mk_quat(16'h0001, 16'h0001, 16'h0001, 16'h0001,
                           16'h0002, 16'hffff, 16'h0001, 16'hfffe));
    op_q.push_back(mk_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                           16'h8000, 16'h8000, 16'h8000, 16'h8000));
    op_q.push_back(mk_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                           16'h8000, 16'h7fff, 16'h8000, 16'h7fff));
    op_q.push_back(mk_quat(16'h2000, 16'h2000, 16'h2000, 16'h2000,
                           16'h2000, 16'he000, 16'h2000, 16'he000));
    op_q.push_back(mk_quat(16'h4001, 0, 0, 0, 16'h3fff, 0, 0, 0));
    op_q.push_back(mk_quat(16'h4000, 0, 0, 0, 16'h4000, 16'h0001, 0, 0));
    op_q.push_back(mk_quat(16'h3fff, 16'h0001, 0, 0, 16'h4000, 0, 16'hffff, 0));
    op_q.push_back(mk_quat(16'h0010, 16'h8000, 16'h0003, 16'h7fff,
                           16'h0005, 16'h0000, 16'hfff0, 16'h0001));
    op_q.push_back(mk_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                           16'h0000, 16'h0000, 16'h0000, 16'h0000));
    // near-one band (unit quaternions nudged by a few lsb), corner values and random components
    for (int i = 0; i < 450; i++) begin
      case ($urandom_range(0, 3))
        0: begin
          for (int k = 0; k < 8; k++) c[k] = 16'(int'($urandom_range(0, 6)) - 3);
          c[$urandom_range(0, 3)] = 16'h4000 + 16'(int'($urandom_range(0, 4)) - 2);
          c[4 + $urandom_range(0, 3)] = 16'hc000 + 16'(int'($urandom_range(0, 4)) - 2);
        end
        1: for (int k = 0; k < 8; k++) c[k] = pick_comp();
        default: for (int k = 0; k < 8; k++) c[k] = 16'($urandom());
      endcase
      op_q.push_back(mk_quat(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]));
    end

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);
    for (int i = 0; i < op_q.size(); i++) begin
      if (i == 200) drain_all();
      if (i == op_q.size() - 80) calm = 1'b1;
      send_operands(op_q[i]);
    end
    drain_all();
    repeat (80) @(negedge clk_i);
    if (board.errors == 0 && board.want_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule

>>> quaternion_multiply_normalize.f
rtl/core/qmn_pkg.sv
rtl/core/qmn_front.sv
rtl/core/qmn_fifo.sv
rtl/core/qmn_isqrt.sv
rtl/core/qmn_div.sv
rtl/core/quaternion_multiply_normalize.sv
verif/tb_quaternion_multiply_normalize.sv
